>>> sv/lgfp_pkg.sv
// Shared types and constants of the LED grid flash and pulse engine.
package lgfp_pkg;

    localparam int COLUMNS_DEF     = 10;
    localparam int ROWS_DEF        = 8;
    localparam int FLASH_SLOTS_DEF = 16;
    localparam int PULSE_SLOTS_DEF = 16;

    localparam int LOG_ROWS = 16;
    localparam int CH_W     = 8;
    localparam int POS_W    = 4;
    localparam int CFG_W    = 16;
    localparam int CNT_W    = 5;
    localparam int STEP_W   = 5;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    localparam logic [STEP_W-1:0] STEP_MAX  = 5'd20;
    localparam logic [STEP_W-1:0] FALL_BASE = 5'd19;
    localparam logic [STEP_W-1:0] RISE_TOP  = 5'd3;

    localparam logic [1:0] MODE_STEADY = 2'd0;
    localparam logic [1:0] MODE_FLASH  = 2'd1;
    localparam logic [1:0] MODE_PULSE  = 2'd2;
    localparam logic [1:0] MODE_BAD    = 2'd3;

    localparam logic [1:0] REG_FLASH_PER = 2'd0;
    localparam logic [1:0] REG_PULSE_PER = 2'd1;
    localparam logic [1:0] REG_STEP_CNT  = 2'd2;

    localparam logic [CFG_W-1:0] FLASH_PER_RST = 16'd250;
    localparam logic [CFG_W-1:0] PULSE_PER_RST = 16'd20;

    typedef enum logic [1:0] {SRC_REQ, SRC_FLASH, SRC_PULSE} rd_src_t;
    typedef enum logic [1:0] {EM_SET, EM_FALT, EM_FMAIN, EM_PULSE} em_kind_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SET_ISSUE, ST_SET_RD, ST_FSRCH, ST_FMOVE, ST_PSRCH, ST_PMOVE,
        ST_APPLY, ST_SET_EMIT, ST_TICK_F, ST_F_ITEM, ST_F_ALT, ST_F_MAIN,
        ST_TICK_P, ST_P_ITEM, ST_P_CALC, ST_P_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic [1:0]      mode;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } cell_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [CH_W-1:0]  r;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  b;
    } flash_ent_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } pulse_ent_t;

    typedef struct packed {
        logic     accept;
        logic     store_rd;
        rd_src_t  rd_src;
        logic     idx_clr;
        logic     idx_inc;
        logic     f_move;
        logic     p_move;
        logic     apply;
        logic     p_calc;
        logic     emit;
        em_kind_t em_kind;
    } cmd_t;

    typedef struct packed {
        logic       is_tick;
        logic       req_bad;
        logic [1:0] cell_mode;
        logic       f_more;
        logic       p_more;
        logic       f_match;
        logic       p_match;
        logic       eff_pulse;
        logic       f_fire;
        logic       p_fire;
        logic       f_phase;
        logic       out_free;
    } stat_t;

endpackage

>>> sv/led_grid_flash_pulse_engine_unit.sv
// Set command: reads the store, searches the old flash or pulse list of the LED and
// swap-removes it when found, then applies; steady or flash also emits, waiting on a stall.
// Tick: sweeps the flashing LEDs when the flash timer fires, then the pulsing LEDs when
// the pulse timer fires, with a store read and a dimming step before each pulse write.
// One item at a time; s_tready is high only between items, output register decouples m_tready.
// Reset (aresetn low, synchronous): store reads as zero steady, lists empty, timers and
// phase/step cleared, registers back to 250 / 20 / 20.
module led_grid_flash_pulse_engine_unit #(
    parameter int COLUMNS     = lgfp_pkg::COLUMNS_DEF,
    parameter int ROWS        = lgfp_pkg::ROWS_DEF,
    parameter int FLASH_SLOTS = lgfp_pkg::FLASH_SLOTS_DEF,
    parameter int PULSE_SLOTS = lgfp_pkg::PULSE_SLOTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // pos_x[3:0], pos_y[7:4], mode[9:8], red[17:10], green[25:18], blue[33:26]
    input  logic [lgfp_pkg::IN_W-1:0]   s_tdata,
    // func[0]
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // phys_col[4:0], phys_row[7:5], direct[8], out_red[16:9], out_green[24:17],
    // out_blue[32:25]
    output logic [lgfp_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tlast,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_wr_addr,
    input  logic [lgfp_pkg::CFG_W-1:0]  cfg_wr_data
);

    lgfp_pkg::cmd_t  cmd;
    lgfp_pkg::stat_t stat;

    lgfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lgfp_dp #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .FLASH_SLOTS (FLASH_SLOTS),
        .PULSE_SLOTS (PULSE_SLOTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

>>> sv/lgfp_ctrl.sv
// Controller state machine: sequences set commands and tick sweeps.
module lgfp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lgfp_pkg::stat_t  stat,
    output lgfp_pkg::cmd_t   cmd
);

    lgfp_pkg::state_t state_reg, state_next;
    logic accept;

    assign s_tready = (state_reg == lgfp_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lgfp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lgfp_pkg::ST_IDLE: begin
                if (accept) begin
                    if (stat.is_tick) state_next = lgfp_pkg::ST_TICK_F;
                    else if (!stat.req_bad) state_next = lgfp_pkg::ST_SET_ISSUE;
                end
            end
            lgfp_pkg::ST_SET_ISSUE: state_next = lgfp_pkg::ST_SET_RD;
            lgfp_pkg::ST_SET_RD: begin
                if (stat.cell_mode == lgfp_pkg::MODE_FLASH) state_next = lgfp_pkg::ST_FSRCH;
                else if (stat.cell_mode == lgfp_pkg::MODE_PULSE) state_next = lgfp_pkg::ST_PSRCH;
                else state_next = lgfp_pkg::ST_APPLY;
            end
            lgfp_pkg::ST_FSRCH: begin
                if (!stat.f_more) state_next = lgfp_pkg::ST_APPLY;
                else if (stat.f_match) state_next = lgfp_pkg::ST_FMOVE;
            end
            lgfp_pkg::ST_FMOVE: state_next = lgfp_pkg::ST_APPLY;
            lgfp_pkg::ST_PSRCH: begin
                if (!stat.p_more) state_next = lgfp_pkg::ST_APPLY;
                else if (stat.p_match) state_next = lgfp_pkg::ST_PMOVE;
            end
            lgfp_pkg::ST_PMOVE: state_next = lgfp_pkg::ST_APPLY;
            lgfp_pkg::ST_APPLY: begin
                if (stat.eff_pulse) state_next = lgfp_pkg::ST_IDLE;
                else state_next = lgfp_pkg::ST_SET_EMIT;
            end
            lgfp_pkg::ST_SET_EMIT: begin
                if (stat.out_free) state_next = lgfp_pkg::ST_IDLE;
            end
            lgfp_pkg::ST_TICK_F: begin
                if (stat.f_fire) state_next = lgfp_pkg::ST_F_ITEM;
                else state_next = lgfp_pkg::ST_TICK_P;
            end
            lgfp_pkg::ST_F_ITEM: begin
                if (!stat.f_more) state_next = lgfp_pkg::ST_TICK_P;
                else if (stat.f_phase) state_next = lgfp_pkg::ST_F_MAIN;
                else state_next = lgfp_pkg::ST_F_ALT;
            end
            lgfp_pkg::ST_F_ALT, lgfp_pkg::ST_F_MAIN: begin
                if (stat.out_free) state_next = lgfp_pkg::ST_F_ITEM;
            end
            lgfp_pkg::ST_TICK_P: begin
                if (stat.p_fire) state_next = lgfp_pkg::ST_P_ITEM;
                else state_next = lgfp_pkg::ST_IDLE;
            end
            lgfp_pkg::ST_P_ITEM: begin
                if (!stat.p_more) state_next = lgfp_pkg::ST_IDLE;
                else state_next = lgfp_pkg::ST_P_CALC;
            end
            lgfp_pkg::ST_P_CALC: state_next = lgfp_pkg::ST_P_EMIT_WAIT;
            lgfp_pkg::ST_P_EMIT_WAIT: begin
                if (stat.out_free) state_next = lgfp_pkg::ST_P_ITEM;
            end
            default: state_next = lgfp_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd = '0;
        case (state_reg)
            lgfp_pkg::ST_IDLE: cmd.accept = accept;
            lgfp_pkg::ST_SET_ISSUE: begin
                cmd.store_rd = 1'b1;
                cmd.rd_src   = lgfp_pkg::SRC_REQ;
            end
            lgfp_pkg::ST_SET_RD: cmd.idx_clr = 1'b1;
            lgfp_pkg::ST_FSRCH: cmd.idx_inc = stat.f_more && !stat.f_match;
            lgfp_pkg::ST_FMOVE: cmd.f_move = 1'b1;
            lgfp_pkg::ST_PSRCH: cmd.idx_inc = stat.p_more && !stat.p_match;
            lgfp_pkg::ST_PMOVE: cmd.p_move = 1'b1;
            lgfp_pkg::ST_APPLY: cmd.apply = 1'b1;
            lgfp_pkg::ST_SET_EMIT: begin
                cmd.emit    = stat.out_free;
                cmd.em_kind = lgfp_pkg::EM_SET;
            end
            lgfp_pkg::ST_TICK_F, lgfp_pkg::ST_TICK_P: cmd.idx_clr = 1'b1;
            lgfp_pkg::ST_F_ITEM: begin
                cmd.store_rd = stat.f_more && stat.f_phase;
                cmd.rd_src   = lgfp_pkg::SRC_FLASH;
            end
            lgfp_pkg::ST_F_ALT: begin
                cmd.emit    = stat.out_free;
                cmd.idx_inc = stat.out_free;
                cmd.em_kind = lgfp_pkg::EM_FALT;
            end
            lgfp_pkg::ST_F_MAIN: begin
                cmd.emit    = stat.out_free;
                cmd.idx_inc = stat.out_free;
                cmd.em_kind = lgfp_pkg::EM_FMAIN;
            end
            lgfp_pkg::ST_P_ITEM: begin
                cmd.store_rd = stat.p_more;
                cmd.rd_src   = lgfp_pkg::SRC_PULSE;
            end
            lgfp_pkg::ST_P_CALC: cmd.p_calc = 1'b1;
            lgfp_pkg::ST_P_EMIT_WAIT: begin
                cmd.emit    = stat.out_free;
                cmd.idx_inc = stat.out_free;
                cmd.em_kind = lgfp_pkg::EM_PULSE;
            end
            default: cmd = '0;
        endcase
    end

endmodule

>>> sv/lgfp_dp.sv
// Datapath: LED store, flash and pulse lists, timers, dimming and output register.
module lgfp_dp #(
    parameter int COLUMNS     = lgfp_pkg::COLUMNS_DEF,
    parameter int ROWS        = lgfp_pkg::ROWS_DEF,
    parameter int FLASH_SLOTS = lgfp_pkg::FLASH_SLOTS_DEF,
    parameter int PULSE_SLOTS = lgfp_pkg::PULSE_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lgfp_pkg::IN_W-1:0]     s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lgfp_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_wr_addr,
    input  logic [lgfp_pkg::CFG_W-1:0]    cfg_wr_data,
    input  lgfp_pkg::cmd_t                cmd,
    output lgfp_pkg::stat_t               stat
);

    localparam int SD   = COLUMNS * lgfp_pkg::LOG_ROWS;
    localparam int SAW  = $clog2(SD);
    localparam int FIW  = (FLASH_SLOTS > 1) ? $clog2(FLASH_SLOTS) : 1;
    localparam int PIW  = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;
    localparam int CW   = lgfp_pkg::CNT_W;
    localparam int PW   = lgfp_pkg::POS_W;
    localparam int CHW  = lgfp_pkg::CH_W;
    localparam int SW   = lgfp_pkg::STEP_W;
    localparam int MW   = CHW + SW;

    // Input decode
    logic [PW-1:0]  in_x, in_y;
    logic [1:0]     in_mode;
    assign in_x    = s_tdata[3:0];
    assign in_y    = s_tdata[7:4];
    assign in_mode = s_tdata[9:8];

    // Latched request
    logic [PW-1:0]  req_x_reg, req_y_reg;
    logic [1:0]     req_mode_reg;
    logic [CHW-1:0] req_r_reg, req_g_reg, req_b_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_x_reg    <= in_x;
            req_y_reg    <= in_y;
            req_mode_reg <= in_mode;
            req_r_reg    <= s_tdata[17:10];
            req_g_reg    <= s_tdata[25:18];
            req_b_reg    <= s_tdata[33:26];
        end
    end

    // Configuration registers
    logic [lgfp_pkg::CFG_W-1:0] fper_reg, pper_reg;
    logic [SW-1:0]              scnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fper_reg <= lgfp_pkg::FLASH_PER_RST;
            pper_reg <= lgfp_pkg::PULSE_PER_RST;
            scnt_reg <= lgfp_pkg::STEP_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                lgfp_pkg::REG_FLASH_PER: fper_reg <= cfg_wr_data;
                lgfp_pkg::REG_PULSE_PER: pper_reg <= cfg_wr_data;
                lgfp_pkg::REG_STEP_CNT:  scnt_reg <= cfg_wr_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // Loop index and list counts
    logic [CW-1:0] idx_reg, fcnt_reg, pcnt_reg;
    lgfp_pkg::flash_ent_t fl_reg [FLASH_SLOTS];
    lgfp_pkg::pulse_ent_t pl_reg [PULSE_SLOTS];
    logic [CW-1:0] f_rd_idx, p_rd_idx;
    lgfp_pkg::flash_ent_t f_ent;
    lgfp_pkg::pulse_ent_t p_ent;
    logic f_full, p_full;
    logic [1:0] eff_mode;
    lgfp_pkg::cell_t cur_cell;

    assign f_rd_idx = cmd.f_move ? (fcnt_reg - CW'(1)) : idx_reg;
    assign p_rd_idx = cmd.p_move ? (pcnt_reg - CW'(1)) : idx_reg;
    assign f_ent    = fl_reg[f_rd_idx[FIW-1:0]];
    assign p_ent    = pl_reg[p_rd_idx[PIW-1:0]];
    assign f_full   = (fcnt_reg >= CW'(FLASH_SLOTS));
    assign p_full   = (pcnt_reg >= CW'(PULSE_SLOTS));

    // Fall back to steady when the target list is full
    always_comb begin
        eff_mode = req_mode_reg;
        if ((req_mode_reg == lgfp_pkg::MODE_FLASH && f_full) ||
            (req_mode_reg == lgfp_pkg::MODE_PULSE && p_full)) begin
            eff_mode = lgfp_pkg::MODE_STEADY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcnt_reg <= '0;
            pcnt_reg <= '0;
        end else begin
            if (cmd.f_move) fcnt_reg <= fcnt_reg - CW'(1);
            else if (cmd.apply && eff_mode == lgfp_pkg::MODE_FLASH)
                fcnt_reg <= fcnt_reg + CW'(1);
            if (cmd.p_move) pcnt_reg <= pcnt_reg - CW'(1);
            else if (cmd.apply && eff_mode == lgfp_pkg::MODE_PULSE)
                pcnt_reg <= pcnt_reg + CW'(1);
        end
    end

    // List updates: swap-remove moves the last entry, append at the count
    always_ff @(posedge aclk) begin
        if (cmd.f_move) begin
            fl_reg[idx_reg[FIW-1:0]] <= f_ent;
        end else if (cmd.apply && eff_mode == lgfp_pkg::MODE_FLASH) begin
            fl_reg[fcnt_reg[FIW-1:0]] <= '{x: req_x_reg, y: req_y_reg,
                                           r: cur_cell.r, g: cur_cell.g, b: cur_cell.b};
        end
        if (cmd.p_move) begin
            pl_reg[idx_reg[PIW-1:0]] <= p_ent;
        end else if (cmd.apply && eff_mode == lgfp_pkg::MODE_PULSE) begin
            pl_reg[pcnt_reg[PIW-1:0]] <= '{x: req_x_reg, y: req_y_reg};
        end
    end

    // LED store with per-entry valid bits; invalid reads as zero and steady
    lgfp_pkg::cell_t mem [SD];
    logic [SD-1:0]   vld_reg;
    lgfp_pkg::cell_t rd_mem_reg;
    logic            rd_vld_reg;
    logic [SAW-1:0]  rd_addr, wr_addr;
    logic [PW-1:0]   fx_mod, px_mod;

    assign fx_mod = ({1'b0, f_ent.x} >= (PW+1)'(COLUMNS)) ? f_ent.x - PW'(COLUMNS) : f_ent.x;
    assign px_mod = ({1'b0, p_ent.x} >= (PW+1)'(COLUMNS)) ? p_ent.x - PW'(COLUMNS) : p_ent.x;
    assign wr_addr = SAW'({req_x_reg, req_y_reg});

    always_comb begin
        case (cmd.rd_src)
            lgfp_pkg::SRC_FLASH: rd_addr = SAW'({fx_mod, f_ent.y});
            lgfp_pkg::SRC_PULSE: rd_addr = SAW'({px_mod, p_ent.y});
            default:             rd_addr = wr_addr;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_rd) begin
            rd_mem_reg <= mem[rd_addr];
        end
        if (cmd.apply) begin
            mem[wr_addr] <= '{mode: eff_mode, r: req_r_reg, g: req_g_reg, b: req_b_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (cmd.store_rd) rd_vld_reg <= vld_reg[rd_addr];
            if (cmd.apply) vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign cur_cell = rd_vld_reg ? rd_mem_reg : '0;

    // Millisecond timers, flash phase and pulse step
    logic [lgfp_pkg::CFG_W-1:0] fwait_reg, pwait_reg;
    logic f_fire_reg, p_fire_reg, f_phase_reg;
    logic [SW-1:0] pstep_reg, step_inc, step_lim;
    logic tick_acc, f_zero, p_zero;

    assign tick_acc = cmd.accept && s_tuser;
    assign f_zero   = (fwait_reg == '0);
    assign p_zero   = (pwait_reg == '0);
    assign step_inc = pstep_reg + SW'(1);
    assign step_lim = (scnt_reg > lgfp_pkg::STEP_MAX) ? lgfp_pkg::STEP_MAX : scnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwait_reg   <= '0;
            pwait_reg   <= '0;
            f_fire_reg  <= 1'b0;
            p_fire_reg  <= 1'b0;
            f_phase_reg <= 1'b0;
            pstep_reg   <= '0;
        end else if (tick_acc) begin
            f_fire_reg <= f_zero;
            p_fire_reg <= p_zero;
            if (f_zero) begin
                fwait_reg   <= (fper_reg == '0) ? '0 : fper_reg - 16'd1;
                f_phase_reg <= !f_phase_reg;
            end else begin
                fwait_reg <= fwait_reg - 16'd1;
            end
            if (p_zero) begin
                pwait_reg <= (pper_reg == '0) ? '0 : pper_reg - 16'd1;
                pstep_reg <= (step_inc >= step_lim) ? '0 : step_inc;
            end else begin
                pwait_reg <= pwait_reg - 16'd1;
            end
        end
    end

    // Dimming: first stage multiplies the stored colour, second the rising green
    logic [SW-1:0]  rise_k, fall_k;
    logic [MW-1:0]  mul_rr, mul_fr, mul_fg, mul_fb, mul_g2;
    logic [CHW-1:0] dr_reg, dg_reg, db_reg, g2;
    logic           dlow_reg;

    assign rise_k = step_inc;
    assign fall_k = lgfp_pkg::FALL_BASE - pstep_reg;
    assign mul_rr = MW'(cur_cell.r) * MW'(rise_k);
    assign mul_fr = MW'(cur_cell.r) * MW'(fall_k);
    assign mul_fg = MW'(cur_cell.g) * MW'(fall_k);
    assign mul_fb = MW'(cur_cell.b) * MW'(fall_k);
    assign mul_g2 = MW'(dr_reg) * MW'(rise_k);
    assign g2     = mul_g2[CHW+1:2];

    always_ff @(posedge aclk) begin
        if (cmd.p_calc) begin
            dlow_reg <= (pstep_reg <= lgfp_pkg::RISE_TOP);
            if (pstep_reg <= lgfp_pkg::RISE_TOP) begin
                dr_reg <= mul_rr[CHW+1:2];
            end else begin
                dr_reg <= mul_fr[CHW+3:4];
            end
            dg_reg <= mul_fg[CHW+3:4];
            db_reg <= mul_fb[CHW+3:4];
        end
    end

    // Select the driver write
    logic [PW-1:0]  e_x, e_y;
    logic [CHW-1:0] e_r, e_g, e_b;
    logic           e_last, f_tail, p_tail;
    logic [4:0]     e_col;
    logic [2:0]     e_row;
    logic [2:0]     row_map [lgfp_pkg::LOG_ROWS];
    logic           m_valid_reg, m_last_reg;
    logic [lgfp_pkg::OUT_W-1:0] m_data_reg;
    logic           out_free;

    assign f_tail = (idx_reg == fcnt_reg - CW'(1)) && !(p_fire_reg && pcnt_reg != '0);
    assign p_tail = (idx_reg == pcnt_reg - CW'(1));

    always_comb begin
        case (cmd.em_kind)
            lgfp_pkg::EM_FALT: begin
                e_x = f_ent.x; e_y = f_ent.y;
                e_r = f_ent.r; e_g = f_ent.g; e_b = f_ent.b;
                e_last = f_tail;
            end
            lgfp_pkg::EM_FMAIN: begin
                e_x = f_ent.x; e_y = f_ent.y;
                e_r = cur_cell.r; e_g = cur_cell.g; e_b = cur_cell.b;
                e_last = f_tail;
            end
            lgfp_pkg::EM_PULSE: begin
                e_x = p_ent.x; e_y = p_ent.y;
                e_r = dr_reg;
                e_g = dlow_reg ? g2 : dg_reg;
                e_b = dlow_reg ? g2 : db_reg;
                e_last = p_tail;
            end
            default: begin
                e_x = req_x_reg; e_y = req_y_reg;
                e_r = req_r_reg; e_g = req_g_reg; e_b = req_b_reg;
                e_last = 1'b1;
            end
        endcase
    end

    // Fold each logical row onto its physical row as a constant table
    for (genvar gi = 0; gi < lgfp_pkg::LOG_ROWS; gi++) begin : g_row_map
        assign row_map[gi] = 3'(gi % ROWS);
    end

    // Map logical rows beyond the physical rows onto extra columns
    assign e_col = ({1'b0, e_y} >= 5'(ROWS)) ? ({1'b0, e_x} + 5'(COLUMNS)) : {1'b0, e_x};
    assign e_row = row_map[e_y];

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {7'd0, e_b, e_g, e_r, e_x[3], e_row, e_col};
            m_last_reg <= e_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Status
    always_comb begin
        stat           = '0;
        stat.is_tick   = s_tuser;
        stat.req_bad   = ({1'b0, in_x} >= (PW+1)'(COLUMNS)) || (in_mode == lgfp_pkg::MODE_BAD);
        stat.cell_mode = cur_cell.mode;
        stat.f_more    = (idx_reg < fcnt_reg);
        stat.p_more    = (idx_reg < pcnt_reg);
        stat.f_match   = (f_ent.x == req_x_reg) && (f_ent.y == req_y_reg);
        stat.p_match   = (p_ent.x == req_x_reg) && (p_ent.y == req_y_reg);
        stat.eff_pulse = (eff_mode == lgfp_pkg::MODE_PULSE);
        stat.f_fire    = f_fire_reg;
        stat.p_fire    = p_fire_reg;
        stat.f_phase   = f_phase_reg;
        stat.out_free  = out_free;
    end

    // Checks
    a_fcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= CW'(FLASH_SLOTS)) else $error("flash list count overflow");
    a_pcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pcnt_reg <= CW'(PULSE_SLOTS)) else $error("pulse list count overflow");
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pstep_reg < lgfp_pkg::STEP_MAX) else $error("pulse step out of range");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free) else $error("driver write overwrites pending transaction");
    a_phase_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_acc && f_zero) |=> (f_phase_reg != $past(f_phase_reg)))
        else $error("flash phase did not toggle on expiry");

endmodule
